// File: src/gpbe_pkg.sv
// shared types, constants and lookup functions for the gaussian polynomial basis unit
// no dependencies
`default_nettype none
package gpbe_pkg;

	localparam int MAX_PARAMS = 8;
	localparam int MAX_COEFFS = 2048;
	localparam int RANK_LIMIT = 5;
	localparam int ADDR_W     = $clog2(MAX_COEFFS);
	localparam int COUNT_W    = ADDR_W + 1;
	localparam int PIDX_W     = $clog2(MAX_PARAMS);

	localparam logic [24:0] LOG2E_Q24  = 25'd24204406;
	localparam logic [40:0] U_CLAMP    = 41'd1 << 30;
	localparam logic [46:0] PART_LIMIT = 47'd1 << 39;
	localparam logic [16:0] WEIGHT_ONE = 17'd65536;

	typedef enum logic [1:0] {
		FUNC_BUILD = 2'd0,
		FUNC_THETA = 2'd1,
		FUNC_EVAL  = 2'd2,
		FUNC_NONE  = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_RANGE     = 2'd1,
		ST_NOT_BUILT = 2'd2,
		ST_SAT       = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_NUM_PARAMS = 2'd0,
		CFG_MAX_RANK   = 2'd1,
		CFG_LAMBDA_INV = 2'd2,
		CFG_UNUSED     = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BD_IDLE,
		BD_ZERO,
		BD_RUN,
		BD_DONE
	} bld_state_t;

	typedef enum logic [3:0] {
		EV_IDLE,
		EV_READ,
		EV_SQX,
		EV_SQACC,
		EV_LOG,
		EV_MANT,
		EV_SCALE,
		EV_FX,
		EV_FLO,
		EV_FHI,
		EV_DONE
	} eval_state_t;

	typedef logic [RANK_LIMIT-1:0][2:0] tuple_t;

	// one coefficient table row
	typedef struct packed {
		logic [2:0]  rank;
		tuple_t      idx;
		logic [16:0] weight;
	} coeff_entry_t;

	typedef struct packed {
		logic               busy;
		logic               done;
		logic [COUNT_W-1:0] count;
	} bld_stat_t;

	typedef struct packed {
		logic        busy;
		logic        done;
		logic [31:0] value;
		status_t     status;
	} eval_res_t;

	// 2^(-k/16) in q1.16
	function automatic logic [16:0] pow2_frac(input logic [4:0] k);
		case (k)
			5'd0:    pow2_frac = 17'd65536;
			5'd1:    pow2_frac = 17'd62757;
			5'd2:    pow2_frac = 17'd60097;
			5'd3:    pow2_frac = 17'd57549;
			5'd4:    pow2_frac = 17'd55109;
			5'd5:    pow2_frac = 17'd52773;
			5'd6:    pow2_frac = 17'd50535;
			5'd7:    pow2_frac = 17'd48393;
			5'd8:    pow2_frac = 17'd46341;
			5'd9:    pow2_frac = 17'd44376;
			5'd10:   pow2_frac = 17'd42495;
			5'd11:   pow2_frac = 17'd40693;
			5'd12:   pow2_frac = 17'd38968;
			5'd13:   pow2_frac = 17'd37316;
			5'd14:   pow2_frac = 17'd35734;
			5'd15:   pow2_frac = 17'd34219;
			5'd16:   pow2_frac = 17'd32768;
			default: pow2_frac = 17'd0;
		endcase
	endfunction

	function automatic logic [6:0] fact(input logic [2:0] n);
		case (n)
			3'd0, 3'd1: fact = 7'd1;
			3'd2:       fact = 7'd2;
			3'd3:       fact = 7'd6;
			3'd4:       fact = 7'd24;
			3'd5:       fact = 7'd120;
			default:    fact = 7'd0;
		endcase
	endfunction

	function automatic logic [16:0] inv_sqrt(input logic [6:0] p);
		case (p)
			7'd1:    inv_sqrt = 17'd65536;
			7'd2:    inv_sqrt = 17'd46341;
			7'd4:    inv_sqrt = 17'd32768;
			7'd6:    inv_sqrt = 17'd26755;
			7'd12:   inv_sqrt = 17'd18919;
			7'd24:   inv_sqrt = 17'd13377;
			7'd120:  inv_sqrt = 17'd5983;
			default: inv_sqrt = 17'd0;
		endcase
	endfunction

	// 1/sqrt of the product of factorials of the runs of equal indices
	function automatic logic [16:0] tuple_weight(input tuple_t t, input logic [2:0] r);
		logic [6:0]  p;
		logic [2:0]  run;
		logic [13:0] prod;
		p   = 7'd1;
		run = 3'd1;
		for (int j = 1; j < RANK_LIMIT; j++) begin
			if (3'(j) < r) begin
				if (t[j] == t[j-1]) begin
					run = run + 3'd1;
				end else begin
					prod = p * fact(run);
					p    = prod[6:0];
					run  = 3'd1;
				end
			end
		end
		prod = p * fact(run);
		p    = prod[6:0];
		if (r == 3'd0)
			tuple_weight = WEIGHT_ONE;
		else
			tuple_weight = inv_sqrt(p);
	endfunction

endpackage
`default_nettype wire

// File: src/gpbe_ram.sv
// generic single write port ram with a registered read port
// no dependencies
`default_nettype none
module gpbe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem_q[waddr] <= wdata;
		if (re)
			rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: src/gpbe_build.sv
// coefficient table builder: walks nonincreasing index tuples, one row per cycle
// depends on gpbe_pkg
`default_nettype none
module gpbe_build (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        go,
	input  wire logic [3:0]                  n,
	input  wire logic [2:0]                  rm,
	output logic                             ram_we,
	output logic [gpbe_pkg::ADDR_W-1:0]      ram_waddr,
	output gpbe_pkg::coeff_entry_t           ram_wdata,
	output gpbe_pkg::bld_stat_t              stat
);
	import gpbe_pkg::*;

	bld_state_t         state_q, state_d;
	logic [2:0]         r_q;
	tuple_t             t_q;
	logic [COUNT_W-1:0] cnt_q;

	logic [2:0] nm1;
	logic       adv;
	tuple_t     t_next;
	tuple_t     t_mask;
	logic       full;
	logic [2:0] lim;
	logic [2:0] pos;

	assign nm1  = 3'(n - 4'd1);
	assign full = cnt_q >= COUNT_W'(MAX_COEFFS);

	// find the innermost position that can still step up
	always_comb begin
		adv = 1'b0;
		pos = 3'd0;
		for (int j = 0; j < RANK_LIMIT; j++) begin
			lim = (j == 0) ? nm1 : t_q[(j == 0) ? 0 : j-1];
			if (3'(j) < r_q && t_q[j] < lim) begin
				adv = 1'b1;
				pos = 3'(j);
			end
		end
		for (int j = 0; j < RANK_LIMIT; j++) begin
			if (3'(j) < pos)
				t_next[j] = t_q[j];
			else if (3'(j) == pos)
				t_next[j] = t_q[j] + 3'd1;
			else
				t_next[j] = 3'd0;
			t_mask[j] = (3'(j) < r_q) ? t_q[j] : 3'd0;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			BD_IDLE: if (go) state_d = BD_ZERO;
			BD_ZERO: state_d = (n == 4'd0) ? BD_DONE : BD_RUN;
			BD_RUN: begin
				if (full || (!adv && r_q == rm))
					state_d = BD_DONE;
			end
			BD_DONE: state_d = BD_IDLE;
			default: state_d = BD_IDLE;
		endcase
	end

	always_comb begin
		ram_we           = 1'b0;
		ram_waddr        = cnt_q[ADDR_W-1:0];
		ram_wdata.rank   = r_q;
		ram_wdata.idx    = t_mask;
		ram_wdata.weight = tuple_weight(t_q, r_q);
		stat.busy        = state_q != BD_IDLE;
		stat.done        = state_q == BD_DONE;
		stat.count       = cnt_q;
		case (state_q)
			BD_ZERO: begin
				ram_we           = 1'b1;
				ram_waddr        = '0;
				ram_wdata.rank   = 3'd0;
				ram_wdata.idx    = '0;
				ram_wdata.weight = WEIGHT_ONE;
			end
			BD_RUN:  ram_we = !full;
			default: ram_we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BD_IDLE;
			r_q     <= '0;
			t_q     <= '0;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				BD_ZERO: begin
					cnt_q <= COUNT_W'(1);
					r_q   <= 3'd1;
					t_q   <= '0;
				end
				BD_RUN: begin
					if (!full) begin
						cnt_q <= cnt_q + COUNT_W'(1);
						if (adv) begin
							t_q <= t_next;
						end else begin
							r_q <= r_q + 3'd1;
							t_q <= '0;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule
`default_nettype wire

// File: src/gpbe_eval.sv
// basis evaluator: theta store, sum of squares, exp table and tuple product sequencer
// depends on gpbe_pkg; reads the coefficient table through a registered ram port
`default_nettype none
module gpbe_eval (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          go,
	input  wire logic [gpbe_pkg::ADDR_W-1:0]   coeff_index,
	input  wire logic [3:0]                    n,
	input  wire logic [15:0]                   lambda_inv,
	input  wire logic                          theta_we,
	input  wire logic [gpbe_pkg::PIDX_W-1:0]   theta_addr,
	input  wire logic [15:0]                   theta_wdata,
	output logic                               ram_re,
	output logic [gpbe_pkg::ADDR_W-1:0]        ram_raddr,
	input  wire gpbe_pkg::coeff_entry_t        ram_rdata,
	output gpbe_pkg::eval_res_t                res
);
	import gpbe_pkg::*;

	eval_state_t  state_q, state_d;
	logic [15:0]  theta_q [MAX_PARAMS];
	coeff_entry_t entry_q;
	logic [2:0]   i_q;
	logic [30:0]  x_q;
	logic [40:0]  u_q;
	logic [30:0]  v_q;
	logic [16:0]  mant_q;
	logic [39:0]  acc_q;
	logic [55:0]  plo_q;
	logic         neg_q;
	logic         sat_q;

	logic [2:0]  nm1;
	logic [2:0]  rank_m1;
	logic [2:0]  sel;
	logic [15:0] raw;
	logic [15:0] mag;
	logic [31:0] x_full;
	logic [61:0] sq;
	logic [30:0] uc;
	logic [55:0] vp;
	logic [16:0] pk, pk1, dk;
	logic [31:0] dt;
	logic [33:0] wm;
	logic [7:0]  sh;
	logic [54:0] phi;
	logic [70:0] full;
	logic [46:0] prod;
	logic        part_sat;
	logic [39:0] lim;
	logic        fin_sat;

	assign nm1     = 3'(n - 4'd1);
	assign rank_m1 = entry_q.rank - 3'd1;

	// operand magnitude times lambda_inv, plus the square, exp interpolation, product and saturation terms
	always_comb begin
		sel    = (state_q == EV_FX) ? entry_q.idx[i_q] : i_q;
		raw    = theta_q[sel];
		mag    = raw[15] ? 16'(17'h10000 - {1'b0, raw}) : raw;
		x_full = mag * lambda_inv;
		sq     = x_q * x_q;
		uc     = (u_q > U_CLAMP) ? U_CLAMP[30:0] : u_q[30:0];
		vp     = uc * LOG2E_Q24;
		pk     = pow2_frac({1'b0, v_q[23:20]});
		pk1    = pow2_frac({1'b0, v_q[23:20]} + 5'd1);
		dk     = pk - pk1;
		dt     = dk[11:0] * v_q[19:0];
		wm     = entry_q.weight * mant_q;
		sh     = 8'd8 + {1'b0, v_q[30:24]};
		phi    = acc_q * x_q[30:16];
		full   = {phi, 16'd0} + {15'd0, plo_q};
		prod   = full[70:24];
		part_sat = prod > PART_LIMIT;
		lim    = neg_q ? 40'h0080000000 : 40'h007FFFFFFF;
		fin_sat = sat_q || (acc_q > lim);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			EV_IDLE:  if (go) state_d = EV_READ;
			EV_READ:  state_d = (n == 4'd0) ? EV_LOG : EV_SQX;
			EV_SQX:   state_d = EV_SQACC;
			EV_SQACC: state_d = (i_q == nm1) ? EV_LOG : EV_SQX;
			EV_LOG:   state_d = EV_MANT;
			EV_MANT:  state_d = EV_SCALE;
			EV_SCALE: state_d = (entry_q.rank == 3'd0) ? EV_DONE : EV_FX;
			EV_FX:    state_d = EV_FLO;
			EV_FLO:   state_d = EV_FHI;
			EV_FHI:   state_d = (part_sat || i_q == rank_m1) ? EV_DONE : EV_FX;
			EV_DONE:  state_d = EV_IDLE;
			default:  state_d = EV_IDLE;
		endcase
	end

	always_comb begin
		ram_re     = go && state_q == EV_IDLE;
		ram_raddr  = coeff_index;
		res.busy   = state_q != EV_IDLE;
		res.done   = state_q == EV_DONE;
		res.status = fin_sat ? ST_SAT : ST_OK;
		if (fin_sat)
			res.value = neg_q ? 32'h80000000 : 32'h7FFFFFFF;
		else
			res.value = neg_q ? (32'd0 - acc_q[31:0]) : acc_q[31:0];
	end

	always_ff @(posedge clk) begin
		if (theta_we)
			theta_q[theta_addr] <= theta_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= EV_IDLE;
			i_q     <= '0;
			neg_q   <= 1'b0;
			sat_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				EV_IDLE: begin
					i_q   <= '0;
					neg_q <= 1'b0;
					sat_q <= 1'b0;
				end
				EV_SQACC: i_q <= i_q + 3'd1;
				EV_SCALE: i_q <= '0;
				EV_FX:    neg_q <= neg_q ^ raw[15];
				EV_FHI: begin
					if (part_sat)
						sat_q <= 1'b1;
					else
						i_q <= i_q + 3'd1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			EV_IDLE:  u_q <= '0;
			EV_READ:  entry_q <= ram_rdata;
			EV_SQX:   x_q <= x_full[30:0];
			EV_SQACC: u_q <= u_q + 41'(sq >> 25);
			EV_LOG:   v_q <= vp[54:24];
			EV_MANT:  mant_q <= pk - 17'(dt >> 20);
			EV_SCALE: acc_q <= (sh >= 8'd64) ? 40'd0 : 40'(wm >> sh[5:0]);
			EV_FX:    x_q <= x_full[30:0];
			EV_FLO:   plo_q <= acc_q * x_q[15:0];
			EV_FHI:   if (!part_sat) acc_q <= prod[39:0];
			default: ;
		endcase
	end
endmodule
`default_nettype wire

// File: src/gaussian_polynomial_basis_eval_unit.sv
// top level of the gaussian polynomial basis unit: command port, config registers, result register
// depends on gpbe_pkg, gpbe_ram, gpbe_build, gpbe_eval
`default_nettype none
// A command is taken at a rising edge with start high and busy low. A build command
// (func 0) walks every nonincreasing index tuple of rank 0 up to the clamped max_rank
// and writes one coefficient row per cycle into the table memory (up to 1287 rows at
// eight parameters and rank five); its result reports the new coefficient count. A
// theta write (func 1) gives no result; func 3 is ignored. An evaluate (func 2) reads
// one row from the table, then steps through each parameter for the sum of squares,
// through the log, mantissa and scale states for the exp table, and through each tuple
// factor on the split multiplier, stopping early on saturation. Errors (table not
// built, index out of range) answer in the next cycle. Every result shows on done for
// exactly one cycle; the receiver cannot stall it, and nothing is queued behind it.
// The table memory has no reset: rows past the built count are never read.
module gaussian_polynomial_basis_eval_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic [1:0]  func,
	input  wire logic [2:0]  param_index,
	input  wire logic [15:0] theta_value,
	input  wire logic [10:0] coeff_index,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             done,
	output logic [31:0]      basis_value,
	output logic [11:0]      coeff_count,
	output logic [1:0]       status
);
	import gpbe_pkg::*;

	// configuration registers
	logic [3:0]  num_params_q;
	logic [2:0]  max_rank_q;
	logic [15:0] lambda_inv_q;

	// table state
	logic [COUNT_W-1:0] coeff_total_q;
	logic               table_built_q;

	// result register
	logic        done_q;
	logic [31:0] basis_value_q;
	logic [11:0] coeff_count_q;
	status_t     status_q;

	logic         accept;
	logic [3:0]   n_eff;
	logic [2:0]   rm_eff;
	logic         bld_go, eval_go, err_now;
	status_t      err_status;
	bld_stat_t    bstat;
	eval_res_t    eres;
	logic         ram_we, ram_re;
	logic [ADDR_W-1:0] ram_waddr, ram_raddr;
	coeff_entry_t ram_wdata, ram_rdata;

	assign busy   = bstat.busy | eres.busy;
	assign accept = start && !busy;

	// parameter count saturates at the store size, rank clamps to 2..5
	assign n_eff  = (num_params_q > 4'(MAX_PARAMS)) ? 4'(MAX_PARAMS) : num_params_q;
	assign rm_eff = (max_rank_q < 3'd2) ? 3'd2 :
	                (max_rank_q > 3'(RANK_LIMIT)) ? 3'(RANK_LIMIT) : max_rank_q;

	// decode the accepted transaction
	always_comb begin
		bld_go     = 1'b0;
		eval_go    = 1'b0;
		err_now    = 1'b0;
		err_status = ST_OK;
		if (accept) begin
			case (func)
				FUNC_BUILD: bld_go = 1'b1;
				FUNC_EVAL: begin
					if (!table_built_q) begin
						err_now    = 1'b1;
						err_status = ST_NOT_BUILT;
					end else if ({1'b0, coeff_index} >= coeff_total_q) begin
						err_now    = 1'b1;
						err_status = ST_RANGE;
					end else begin
						eval_go = 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	gpbe_ram #(
		.WIDTH($bits(coeff_entry_t)),
		.DEPTH(MAX_COEFFS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	gpbe_build u_build (
		.clk       (clk),
		.arst_n    (arst_n),
		.go        (bld_go),
		.n         (n_eff),
		.rm        (rm_eff),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.stat      (bstat)
	);

	gpbe_eval u_eval (
		.clk         (clk),
		.arst_n      (arst_n),
		.go          (eval_go),
		.coeff_index (coeff_index),
		.n           (n_eff),
		.lambda_inv  (lambda_inv_q),
		.theta_we    (accept && func == FUNC_THETA),
		.theta_addr  (param_index),
		.theta_wdata (theta_value),
		.ram_re      (ram_re),
		.ram_raddr   (ram_raddr),
		.ram_rdata   (ram_rdata),
		.res         (eres)
	);

	// config writes; the unused index is dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_params_q <= 4'd1;
			max_rank_q   <= 3'd5;
			lambda_inv_q <= 16'd4096;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_NUM_PARAMS: num_params_q <= cfg_data[3:0];
				CFG_MAX_RANK:   max_rank_q   <= cfg_data[2:0];
				CFG_LAMBDA_INV: lambda_inv_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// table bookkeeping, updated when the builder finishes, and the done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coeff_total_q <= '0;
			table_built_q <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			done_q <= err_now | bstat.done | eres.done;
			if (bstat.done) begin
				coeff_total_q <= bstat.count;
				table_built_q <= 1'b1;
			end
		end
	end

	// result payload, one source per cycle at most
	always_ff @(posedge clk) begin
		if (bstat.done) begin
			basis_value_q <= '0;
			coeff_count_q <= bstat.count;
			status_q      <= ST_OK;
		end else if (eres.done) begin
			basis_value_q <= eres.value;
			coeff_count_q <= coeff_total_q;
			status_q      <= eres.status;
		end else if (err_now) begin
			basis_value_q <= '0;
			coeff_count_q <= coeff_total_q;
			status_q      <= err_status;
		end
	end

	assign done        = done_q;
	assign basis_value = basis_value_q;
	assign coeff_count = coeff_count_q;
	assign status      = status_q;
endmodule
`default_nettype wire

// File: src/gpbe_checker.sv
// port level checks for the gaussian polynomial basis unit, bound to the top level
// depends on gpbe_pkg and gaussian_polynomial_basis_eval_unit
`default_nettype none
module gpbe_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        start,
	input wire logic        busy,
	input wire logic [1:0]  func,
	input wire logic        done,
	input wire logic [31:0] basis_value,
	input wire logic [11:0] coeff_count,
	input wire logic [1:0]  status
);
	import gpbe_pkg::*;

	// saturated results carry a rail value
	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		done && status == ST_SAT |-> basis_value == 32'h7FFFFFFF || basis_value == 32'h80000000)
		else $error("saturated result without rail value");

	// error results carry zero
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (status == ST_RANGE || status == ST_NOT_BUILT) |-> basis_value == 32'd0)
		else $error("error result with nonzero value");

	// a built table always holds at least the constant term
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		done && status != ST_NOT_BUILT |-> coeff_count != 12'd0)
		else $error("empty table reported as built");

	// nothing in flight and nothing taken means no result next cycle
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!busy && !start |=> !done)
		else $error("result without transaction");

	// theta writes produce no result
	a_theta_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && func == FUNC_THETA |=> !done)
		else $error("result after theta write");
endmodule

bind gaussian_polynomial_basis_eval_unit gpbe_checker u_gpbe_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.start       (start),
	.busy        (busy),
	.func        (func),
	.done        (done),
	.basis_value (basis_value),
	.coeff_count (coeff_count),
	.status      (status)
);
`default_nettype wire

// File: bench/tb_top.sv
// self-checking bench for gaussian_polynomial_basis_eval_unit: directed and random transactions,
// with an internal predictor of the coefficient table and of the fixed-point basis evaluation
// depends on gpbe_pkg and the rtl of the unit
`default_nettype none
module tb_top;
	import gpbe_pkg::*;

	// one pending transaction: either a register write or a command
	typedef struct {
		bit          is_cfg;
		cfg_reg_t    reg_sel;
		logic [15:0] data;
		func_t       fn;
		logic [2:0]  pidx;
		logic [15:0] theta;
		logic [10:0] cidx;
	} cmd_t;

	typedef struct {
		logic [31:0] value;
		logic [11:0] count;
		status_t     st;
	} answer_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  func = FUNC_NONE;
	logic [2:0]  param_index = '0;
	logic [15:0] theta_value = '0;
	logic [10:0] coeff_index = '0;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = CFG_UNUSED;
	logic [15:0] cfg_data = '0;
	logic        done;
	logic [31:0] basis_value;
	logic [11:0] coeff_count;
	logic [1:0]  status;

	gaussian_polynomial_basis_eval_unit dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.param_index(param_index), .theta_value(theta_value), .coeff_index(coeff_index),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data), .done(done),
		.basis_value(basis_value), .coeff_count(coeff_count), .status(status)
	);

	always #5 clk = ~clk;

	// stimulus and expectation stores
	cmd_t    pending_cmds[$];
	answer_t expected_answers[$];
	cmd_t    cur_cmd;
	bit      holding;
	int      quiet_cycles;
	int      issued;
	int      error_count;

	// predictor copy of the unit state
	logic [15:0] theta_mem[8];
	logic [2:0]  row_rank[MAX_COEFFS];
	logic [2:0]  row_idx[MAX_COEFFS][5];
	logic [16:0] row_weight[MAX_COEFFS];
	int unsigned row_total;
	bit          rows_valid;
	logic [3:0]  p_nparams;
	logic [2:0]  p_rank;
	logic [15:0] p_lambda;

	// 1/sqrt of the product of run-length factorials, q1.16
	function automatic logic [16:0] run_weight(int unsigned t[5], int r);
		int unsigned facts[6] = '{1, 1, 2, 6, 24, 120};
		int unsigned p = 1;
		int unsigned run = 1;
		if (r == 0)
			return 17'd65536;
		for (int j = 1; j < r; j++) begin
			if (t[j] == t[j-1]) begin
				run++;
			end else begin
				p = p * facts[run];
				run = 1;
			end
		end
		p = p * facts[run];
		case (p)
			1:       return 17'd65536;
			2:       return 17'd46341;
			4:       return 17'd32768;
			6:       return 17'd26755;
			12:      return 17'd18919;
			24:      return 17'd13377;
			120:     return 17'd5983;
			default: return 17'd0;
		endcase
	endfunction

	function automatic int clamp_params(int np);
		return (np > MAX_PARAMS) ? MAX_PARAMS : np;
	endfunction

	function automatic int clamp_rank(int mr);
		return (mr < 2) ? 2 : ((mr > RANK_LIMIT) ? RANK_LIMIT : mr);
	endfunction

	// enumerate nonincreasing tuples rank by rank, last index innermost
	task automatic rebuild_rows();
		int unsigned t[5];
		int          n;
		int          rm;
		int unsigned cnt;
		bit          more;
		int          j;
		n  = clamp_params(p_nparams);
		rm = clamp_rank(p_rank);
		row_rank[0]   = 3'd0;
		row_weight[0] = 17'd65536;
		for (int k = 0; k < 5; k++)
			row_idx[0][k] = 3'd0;
		cnt = 1;
		for (int r = 1; r <= rm && n > 0; r++) begin
			t = '{0, 0, 0, 0, 0};
			more = 1'b1;
			while (more && cnt < MAX_COEFFS) begin
				row_rank[cnt] = 3'(r);
				for (int k = 0; k < 5; k++)
					row_idx[cnt][k] = (k < r) ? 3'(t[k]) : 3'd0;
				row_weight[cnt] = run_weight(t, r);
				cnt++;
				// step to the next tuple
				more = 1'b0;
				j = r;
				while (j > 0 && !more) begin
					j--;
					if (t[j] < ((j == 0) ? n - 1 : t[j-1])) begin
						t[j]++;
						for (int k = j + 1; k < r; k++)
							t[k] = 0;
						more = 1'b1;
					end
				end
			end
		end
		row_total  = cnt;
		rows_valid = 1'b1;
	endtask

	// |theta * lambda_inv| in q8.24 and its sign
	function automatic logic [63:0] scaled_mag(int i, output bit neg);
		logic [15:0] raw;
		logic [63:0] m;
		raw = theta_mem[i & 7];
		neg = raw[15];
		m   = neg ? 64'(32'd65536 - raw) : 64'(raw);
		return m * 64'(p_lambda);
	endfunction

	function automatic answer_t eval_basis(int ic);
		answer_t      a;
		int           n;
		bit           nb;
		bit           neg;
		bit           sat;
		logic [63:0]  x;
		logic [63:0]  u;
		logic [63:0]  v;
		logic [63:0]  f;
		logic [63:0]  mant;
		logic [63:0]  acc;
		logic [127:0] prod;
		int unsigned  k;
		int unsigned  sh;
		int unsigned  pw[17] = '{65536, 62757, 60097, 57549, 55109, 52773, 50535, 48393,
			46341, 44376, 42495, 40693, 38968, 37316, 35734, 34219, 32768};
		n   = clamp_params(p_nparams);
		u   = 0;
		neg = 1'b0;
		sat = 1'b0;
		for (int i = 0; i < n; i++) begin
			x = scaled_mag(i, nb);
			u = u + ((x * x) >> 25);
		end
		if (u > (64'd64 << 24))
			u = 64'd64 << 24;
		// exp(-u) as 2^-v with a linear table interpolation of the fraction
		v    = (u * 64'd24204406) >> 24;
		f    = v & 64'hFFFFFF;
		k    = f >> 20;
		mant = pw[k] - (((64'(pw[k] - pw[k+1])) * (f & 64'hFFFFF)) >> 20);
		sh   = 8 + (v >> 24);
		acc  = 64'(row_weight[ic]) * mant;
		acc  = (sh >= 64) ? 64'd0 : (acc >> sh);
		for (int i = 0; i < row_rank[ic] && i < 5 && !sat; i++) begin
			x = scaled_mag(row_idx[ic][i], nb);
			if (nb)
				neg = !neg;
			prod = 128'(acc) * 128'(x);
			acc  = 64'(prod >> 24);
			if (acc > (64'd1 << 39))
				sat = 1'b1;
		end
		if (!sat && acc > (neg ? 64'h80000000 : 64'h7FFFFFFF))
			sat = 1'b1;
		a.count = 12'(row_total);
		if (sat) begin
			a.st    = ST_SAT;
			a.value = neg ? 32'h80000000 : 32'h7FFFFFFF;
		end else begin
			a.st    = ST_OK;
			a.value = neg ? 32'(-acc) : 32'(acc);
		end
		return a;
	endfunction

	// predictor step for an accepted command
	task automatic apply_cmd(cmd_t c);
		answer_t a;
		case (c.fn)
			FUNC_THETA: theta_mem[c.pidx] = c.theta;
			FUNC_BUILD: begin
				rebuild_rows();
				a = '{value: 32'd0, count: 12'(row_total), st: ST_OK};
				expected_answers = {expected_answers, a};
			end
			FUNC_EVAL: begin
				if (!rows_valid)
					a = '{value: 32'd0, count: 12'(row_total), st: ST_NOT_BUILT};
				else if (c.cidx >= row_total)
					a = '{value: 32'd0, count: 12'(row_total), st: ST_RANGE};
				else
					a = eval_basis(c.cidx);
				expected_answers = {expected_answers, a};
			end
			default: ;
		endcase
	endtask

	// sender idle share in percent, by progress through the run
	function automatic int idle_share();
		if (issued < 600)
			return 26;
		else if (issued < 1200)
			return 88;
		return 0;
	endfunction

	// driver: pops commands, holds start until taken, writes registers only when quiet
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start       <= 1'b0;
			cfg_we      <= 1'b0;
			func        <= FUNC_NONE;
			cfg_index   <= CFG_UNUSED;
			holding     = 1'b0;
			quiet_cycles = 0;
		end else begin
			automatic bit   next_start = 1'b0;
			automatic bit   next_we = 1'b0;
			automatic cmd_t c;
			// transaction taken at this edge
			if (start && !busy) begin
				apply_cmd(cur_cmd);
				holding = 1'b0;
			end
			// count idle cycles with nothing outstanding before a register write
			if (expected_answers.size() == 0 && !busy && !holding)
				quiet_cycles++;
			else
				quiet_cycles = 0;
			if (holding) begin
				next_start = 1'b1;
			end else if (pending_cmds.size() > 0) begin
				if (pending_cmds[0].is_cfg) begin
					if (quiet_cycles >= 40) begin
						c = pending_cmds.pop_front();
						case (c.reg_sel)
							CFG_NUM_PARAMS: p_nparams = c.data[3:0];
							CFG_MAX_RANK:   p_rank    = c.data[2:0];
							CFG_LAMBDA_INV: p_lambda  = c.data;
							default: ;
						endcase
						cfg_index    <= c.reg_sel;
						cfg_data     <= c.data;
						next_we      = 1'b1;
						quiet_cycles = 0;
					end
				end else if ($urandom_range(99) >= idle_share()) begin
					c = pending_cmds.pop_front();
					cur_cmd     = c;
					func        <= c.fn;
					param_index <= c.pidx;
					theta_value <= c.theta;
					coeff_index <= c.cidx;
					next_start  = 1'b1;
					holding     = 1'b1;
					issued++;
				end
			end
			start  <= next_start;
			cfg_we <= next_we;
		end
	end

	// monitor: every strobed result is checked against the oldest expectation
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_answers.size() == 0) begin
				$error("unexpected result: basis_value %h coeff_count %0d status %0d",
					basis_value, coeff_count, status);
				error_count++;
			end else begin
				automatic answer_t a = expected_answers.pop_front();
				if (basis_value !== a.value) begin
					$error("basis_value: expected %h, got %h", a.value, basis_value);
					error_count++;
				end
				if (coeff_count !== a.count) begin
					$error("coeff_count: expected %0d, got %0d", a.count, coeff_count);
					error_count++;
				end
				if (status !== a.st) begin
					$error("status: expected %0d, got %0d", a.st, status);
					error_count++;
				end
			end
		end
	end

	// generation-side tracking of the table size so most indices land inside it
	int gen_np;
	int gen_rank;
	int gen_total;

	function automatic int rows_for(int np, int mr);
		int n;
		int total;
		longint b;
		n = clamp_params(np);
		total = 1;
		if (n > 0) begin
			for (int r = 1; r <= clamp_rank(mr); r++) begin
				// binomial(n+r-1, r)
				b = 1;
				for (int i = 1; i <= r; i++)
					b = b * (n + r - i) / i;
				total += int'(b);
			end
		end
		return (total > MAX_COEFFS) ? MAX_COEFFS : total;
	endfunction

	task automatic push_cfg(cfg_reg_t sel, logic [15:0] data);
		cmd_t c;
		c = '{is_cfg: 1'b1, reg_sel: sel, data: data, fn: FUNC_NONE, pidx: 3'd0,
			theta: 16'd0, cidx: 11'd0};
		if (sel == CFG_NUM_PARAMS)
			gen_np = data[3:0];
		if (sel == CFG_MAX_RANK)
			gen_rank = data[2:0];
		pending_cmds = {pending_cmds, c};
	endtask

	task automatic push_cmd(func_t fn, logic [2:0] pidx, logic [15:0] theta, logic [10:0] cidx);
		cmd_t c;
		c = '{is_cfg: 1'b0, reg_sel: CFG_UNUSED, data: 16'd0, fn: fn, pidx: pidx,
			theta: theta, cidx: cidx};
		if (fn == FUNC_BUILD)
			gen_total = rows_for(gen_np, gen_rank);
		pending_cmds = {pending_cmds, c};
	endtask

	function automatic logic [15:0] rand_theta();
		case ($urandom_range(5))
			0:       return 16'($urandom);
			1:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
			default: return 16'($signed($urandom_range(12000)) - 6000);
		endcase
	endfunction

	function automatic logic [15:0] rand_lambda();
		case ($urandom_range(5))
			0:       return 16'($urandom);
			1:       return $urandom_range(1) ? 16'hFFFF : 16'h0000;
			default: return 16'($urandom_range(6000, 500));
		endcase
	endfunction

	function automatic logic [10:0] rand_index();
		if (gen_total == 0 || $urandom_range(9) == 0)
			return 11'($urandom);
		return 11'($urandom_range(gen_total));
	endfunction

	initial begin
		automatic logic [15:0] seed_thetas[8] = '{16'h7FFF, 16'h8000, 16'h0000, 16'h1000,
			16'hF000, 16'h0001, 16'hFFFF, 16'h0800};
		automatic int items = 0;
		gen_np = 1;
		gen_rank = 5;
		gen_total = 0;
		p_nparams = 4'd1;
		p_rank = 3'd5;
		p_lambda = 16'd4096;
		rows_valid = 1'b0;
		row_total = 0;

		// directed: evaluate before any build, fill every theta element, then a build and evaluations up to and past its end
		push_cmd(FUNC_EVAL, 3'd7, 16'hFFFF, 11'd2047);
		for (int i = 0; i < 8; i++)
			push_cmd(FUNC_THETA, 3'(i), seed_thetas[i], 11'h7FF);
		push_cmd(FUNC_NONE, 3'd5, 16'h5555, 11'd3);
		push_cmd(FUNC_BUILD, 3'd0, 16'd0, 11'd0);
		push_cmd(FUNC_EVAL, 3'd0, 16'd0, 11'd0);
		push_cmd(FUNC_EVAL, 3'd0, 16'd0, 11'd5);
		push_cmd(FUNC_EVAL, 3'd0, 16'd0, 11'd6);
		// widest table, then the lambda extremes on a built table
		push_cfg(CFG_NUM_PARAMS, 16'd8);
		push_cfg(CFG_MAX_RANK, 16'd5);
		push_cmd(FUNC_BUILD, 3'd0, 16'd0, 11'd0);
		push_cmd(FUNC_EVAL, 3'd0, 16'd0, 11'd1286);
		push_cmd(FUNC_EVAL, 3'd0, 16'd0, 11'd1287);
		push_cmd(FUNC_EVAL, 3'd0, 16'd0, 11'd1);
		push_cfg(CFG_LAMBDA_INV, 16'hFFFF);
		push_cmd(FUNC_EVAL, 3'd0, 16'd0, 11'd9);
		push_cfg(CFG_LAMBDA_INV, 16'h0000);
		push_cmd(FUNC_EVAL, 3'd0, 16'd0, 11'd300);
		// zero parameters and out-of-range register values that clamp
		push_cfg(CFG_NUM_PARAMS, 16'd0);
		push_cfg(CFG_MAX_RANK, 16'd0);
		push_cmd(FUNC_BUILD, 3'd0, 16'd0, 11'd0);
		push_cmd(FUNC_EVAL, 3'd0, 16'd0, 11'd0);
		push_cmd(FUNC_EVAL, 3'd0, 16'd0, 11'd1);

		// random phases: new settings, usually a build, then mostly evaluations
		while (items < 1750) begin
			case ($urandom_range(7))
				0:       push_cfg(CFG_NUM_PARAMS, 16'($urandom));
				1:       push_cfg(CFG_NUM_PARAMS, $urandom_range(1) ? 16'd8 : 16'd1);
				default: push_cfg(CFG_NUM_PARAMS, 16'($urandom_range(4, 1)));
			endcase
			push_cfg(CFG_MAX_RANK, 16'($urandom));
			push_cfg(CFG_LAMBDA_INV, rand_lambda());
			if ($urandom_range(3) != 0) begin
				push_cmd(FUNC_BUILD, 3'($urandom), 16'($urandom), 11'($urandom));
				items++;
			end
			for (int j = 0; j < 120; j++) begin
				case ($urandom_range(19))
					0, 1, 2, 3: push_cmd(FUNC_THETA, 3'($urandom), rand_theta(), 11'($urandom));
					4:          push_cmd(FUNC_NONE, 3'($urandom), 16'($urandom), 11'($urandom));
					default:    push_cmd(FUNC_EVAL, 3'($urandom), 16'($urandom), rand_index());
				endcase
				items++;
			end
		end

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// drain: all sent, nothing outstanding, then let the block settle
		while (pending_cmds.size() != 0 || holding || start || expected_answers.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// watchdog
	initial begin
		#20000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire

// File: gaussian_polynomial_basis_eval_unit.f
src/gpbe_pkg.sv
src/gpbe_ram.sv
src/gpbe_build.sv
src/gpbe_eval.sv
src/gaussian_polynomial_basis_eval_unit.sv
src/gpbe_checker.sv
bench/tb_top.sv
